// ===== sv/nibble_header_frame_receiver_macros.svh =====
// assertion macros for the nibble header frame receiver checker
// used by nhfr_checker; needs i_clk and i_rst_n in the including scope
`ifndef NIBBLE_HEADER_FRAME_RECEIVER_MACROS_SVH
`define NIBBLE_HEADER_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define NHFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NHFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/nhfr_pkg.sv =====
// shared types and constants for the nibble header frame receiver
// no dependencies
package nhfr_pkg;

    localparam logic [7:0] START_BYTE   = 8'd137;
    localparam logic [7:0] TRAILER_BYTE = 8'd138;
    localparam int         PAYLOAD_DEPTH = 15;
    localparam int         QUEUE_DEPTH   = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EMIT  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [3:0] idx;
        logic [7:0] data;
        logic [3:0] msg_type;
        logic [3:0] msg_length;
    } t_cmd;

endpackage

// ===== sv/nhfr_if.sv =====
// valid/ready channel interfaces for received bytes and message items
// no dependencies
interface nhfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nhfr_msg_if;
    logic       valid;
    logic       ready;
    logic [3:0] msg_type;
    logic [3:0] msg_length;
    logic [3:0] payload_index;
    logic [7:0] payload_byte;
    logic       last;

    modport source (output valid, output msg_type, output msg_length,
                    output payload_index, output payload_byte, output last,
                    input ready);
    modport sink   (input valid, input msg_type, input msg_length,
                    input payload_index, input payload_byte, input last,
                    output ready);
endinterface

// ===== sv/nibble_header_frame_receiver.sv =====
// nibble header frame receiver: rebuilds framed messages from a byte stream
// byte input on i_rx, message items on o_msg (valid/ready handshake)
// needs nhfr_pkg, nhfr_if, nhfr_front, nhfr_queue, nhfr_back
//
// usage:
//   i_rx carries one received byte per item. a frame is the start byte 137,
//   a header byte (upper nibble payload length, lower nibble type), the
//   payload bytes and the trailer 138. any other trailer drops the frame.
//   o_msg gives one item per payload byte (one type-only item for an empty
//   payload), with last set on the final item of the message.
//   the parser pushes store or emit commands into a small command queue and
//   i_rx.ready falls only while the queue is full.
//   the first item of a message is valid once its trailer's emit command has
//   passed the command queue, started the idle emitter and loaded the output
//   register, then one item follows per cycle while o_msg.ready stays high,
//   set by the single read port of the payload store.
//   a stalled o_msg holds its item; the emitter then stops, the queue fills
//   and the byte input stalls once QUEUE_DEPTH commands wait in it.
//   reset (synchronous, active low) returns the parser to waiting for a
//   start byte and empties the queue and output; the payload store is not
//   cleared, as only entries written in the current frame are ever read.
module nibble_header_frame_receiver #(
    parameter int QUEUE_DEPTH = nhfr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nhfr_rx_if.sink     i_rx,
    nhfr_msg_if.source  o_msg
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    nhfr_pkg::t_cmd w_push_cmd;
    nhfr_pkg::t_cmd w_head_cmd;

    nhfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    nhfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty)
    );

    nhfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_head_cmd),
        .o_pop   (w_pop),
        .o_msg   (o_msg)
    );

endmodule

// ===== sv/nhfr_front.sv =====
// frame parser: accepts bytes and turns them into store and emit commands
// depends on nhfr_pkg and nhfr_rx_if
module nhfr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    nhfr_rx_if.sink         i_rx,
    input  logic            i_full,
    output logic            o_push,
    output nhfr_pkg::t_cmd  o_cmd
);

    logic [4:0] r_pos;
    logic [4:0] n_pos;
    logic [3:0] r_len;
    logic [3:0] n_len;
    logic [3:0] r_type;
    logic [3:0] n_type;
    logic       w_acc;
    logic [4:0] w_off;

    assign i_rx.ready = !i_full;
    assign w_acc      = i_rx.valid && !i_full;
    assign w_off      = r_pos - 5'd2;

    always_comb begin
        n_pos            = r_pos;
        n_len            = r_len;
        n_type           = r_type;
        o_push           = 1'b0;
        o_cmd.kind       = nhfr_pkg::CMD_WRITE;
        o_cmd.idx        = w_off[3:0];
        o_cmd.data       = i_rx.rx_byte;
        o_cmd.msg_type   = r_type;
        o_cmd.msg_length = r_len;
        if (w_acc) begin
            if (r_pos == 5'd0) begin
                if (i_rx.rx_byte == nhfr_pkg::START_BYTE) begin
                    n_pos = 5'd1;
                end
            end else if (r_pos == 5'd1) begin
                n_len  = i_rx.rx_byte[7:4];
                n_type = i_rx.rx_byte[3:0];
                n_pos  = 5'd2;
            end else if (r_pos >= {1'b0, r_len} + 5'd2) begin
                // trailer position
                n_pos = 5'd0;
                if (i_rx.rx_byte == nhfr_pkg::TRAILER_BYTE) begin
                    o_push     = 1'b1;
                    o_cmd.kind = nhfr_pkg::CMD_EMIT;
                end
            end else begin
                o_push = 1'b1;
                n_pos  = r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 5'd0;
            r_len  <= 4'd0;
            r_type <= 4'd0;
        end else begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_type <= n_type;
        end
    end

endmodule

// ===== sv/nhfr_queue.sv =====
// short command queue between the parser and the message emitter
// depends on nhfr_pkg
module nhfr_queue #(
    parameter int DEPTH = nhfr_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nhfr_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output nhfr_pkg::t_cmd  o_cmd,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nhfr_pkg::t_cmd   r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/nhfr_back.sv =====
// message emitter: holds the payload store and plays out accepted messages
// depends on nhfr_pkg and nhfr_msg_if
module nhfr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  nhfr_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    nhfr_msg_if.source      o_msg
);

    logic [7:0] r_mem [0:nhfr_pkg::PAYLOAD_DEPTH-1];
    logic [7:0] r_rd;
    logic       r_active;
    logic       n_active;
    logic [3:0] r_idx;
    logic [3:0] n_idx;
    logic [3:0] r_type;
    logic [3:0] r_len;
    logic       r_valid;
    logic       w_load;
    logic       w_last;
    logic       w_start;

    assign o_pop   = !r_active && !i_empty;
    assign w_start = o_pop && (i_cmd.kind == nhfr_pkg::CMD_EMIT);
    assign w_load  = r_active && (!r_valid || o_msg.ready);
    assign w_last  = (r_len == 4'd0) || (r_idx + 4'd1 == r_len);

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        if (w_start) begin
            n_active = 1'b1;
            n_idx    = 4'd0;
        end else if (w_load) begin
            if (w_last) begin
                n_active = 1'b0;
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end
    end

    // store writes and registered read that follows the run index
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.kind == nhfr_pkg::CMD_WRITE)) begin
            r_mem[i_cmd.idx] <= i_cmd.data;
        end
        r_rd <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_type <= i_cmd.msg_type;
            r_len  <= i_cmd.msg_length;
        end
        if (w_load) begin
            o_msg.msg_type      <= r_type;
            o_msg.msg_length    <= r_len;
            o_msg.payload_index <= r_idx;
            o_msg.payload_byte  <= (r_len == 4'd0) ? 8'd0 : r_rd;
            o_msg.last          <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= 4'd0;
            r_valid  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (o_msg.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_msg.valid = r_valid;

endmodule

// ===== sv/nhfr_checker.sv =====
// port-level checks for the nibble header frame receiver, bound to the top
// depends on nibble_header_frame_receiver_macros.svh
`include "nibble_header_frame_receiver_macros.svh"

module nhfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_msg_length,
    input logic [3:0] i_payload_index,
    input logic [7:0] i_payload_byte,
    input logic       i_last
);

    `NHFR_ASSERT_NEXT(a_valid_holds, i_out_valid && !i_out_ready, i_out_valid, "item dropped while stalled")

    `NHFR_ASSERT_NOW(a_empty_msg, i_out_valid && (i_msg_length == 4'd0), i_last && (i_payload_index == 4'd0) && (i_payload_byte == 8'd0), "bad type-only item")

    `NHFR_ASSERT_NOW(a_index_range, i_out_valid && (i_msg_length != 4'd0), i_payload_index < i_msg_length, "payload index beyond length")

    `NHFR_ASSERT_NOW(a_last_place, i_out_valid && (i_msg_length != 4'd0), i_last == (i_payload_index + 4'd1 == i_msg_length), "last marker misplaced")

endmodule

bind nibble_header_frame_receiver nhfr_checker u_nhfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_msg.valid),
    .i_out_ready     (o_msg.ready),
    .i_msg_length    (o_msg.msg_length),
    .i_payload_index (o_msg.payload_index),
    .i_payload_byte  (o_msg.payload_byte),
    .i_last          (o_msg.last)
);
